// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/dtas_pkg.sv =====
// ----------------------------------------------------------------------------
// dtas_pkg
// Types, step codes and calendar tables for the date/time adder.
// ----------------------------------------------------------------------------
package dtas_pkg;

   typedef struct packed {
      logic [24:0]        date_code;
      logic [17:0]        time_code;
      logic signed [31:0] seconds_to_add;
   } req_type;

   typedef struct packed {
      logic [24:0] new_date_code;
      logic [17:0] new_time_code;
      logic [1:0]  status;
   } rsp_type;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_RANGE   = 2'd2;

   typedef enum logic [4:0] {
      S_DATE0, S_DATE1, S_TIME0, S_TIME1, S_LEAP, S_YADJ, S_SECS, S_ERA,
      S_D1460, S_D36524, S_YOE, S_Y100, S_MP, S_DAY, S_HOUR, S_MIN
   } step_type;

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FIN} state_type;

   typedef enum logic [1:0] {DP_IDLE, DP_EST, DP_RES, DP_FIX} div_phase_type;

   typedef struct packed {
      logic     load;
      logic     issue;
      logic     latch;
      logic     finish;
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic input_ok;
   } stat_type;

   // the seconds step divides the sum with its low seven bits stripped
   function automatic logic [17:0] step_divisor(step_type s);
      logic [17:0] k;
      case (s)
         S_SECS:   k = 18'd675;
         S_ERA:    k = 18'd146097;
         S_D1460:  k = 18'd1460;
         S_D36524: k = 18'd36524;
         S_YOE:    k = 18'd365;
         S_MP:     k = 18'd153;
         S_DAY:    k = 18'd5;
         S_HOUR:   k = 18'd3600;
         S_MIN:    k = 18'd60;
         default:  k = 18'd100;
      endcase
      return k;
   endfunction

   // floor(2^26 / divisor) for each step
   function automatic logic [23:0] step_recip(step_type s);
      logic [23:0] r;
      case (s)
         S_SECS:   r = 24'd99420;
         S_ERA:    r = 24'd459;
         S_D1460:  r = 24'd45964;
         S_D36524: r = 24'd1837;
         S_YOE:    r = 24'd183859;
         S_MP:     r = 24'd438620;
         S_DAY:    r = 24'd13421772;
         S_HOUR:   r = 24'd18641;
         S_MIN:    r = 24'd1118481;
         default:  r = 24'd671088;
      endcase
      return r;
   endfunction

   // days from March 1 to the first of the month
   function automatic logic [8:0] month_offset(logic [3:0] m);
      logic [8:0] v;
      case (m)
         4'd1:    v = 9'd306;
         4'd2:    v = 9'd337;
         4'd4:    v = 9'd31;
         4'd5:    v = 9'd61;
         4'd6:    v = 9'd92;
         4'd7:    v = 9'd122;
         4'd8:    v = 9'd153;
         4'd9:    v = 9'd184;
         4'd10:   v = 9'd214;
         4'd11:   v = 9'd245;
         4'd12:   v = 9'd275;
         4'd13:   v = 9'd306;
         4'd14:   v = 9'd337;
         4'd15:   v = 9'd367;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   function automatic logic [4:0] month_len(logic [3:0] m);
      logic [4:0] v;
      case (m)
         4'd2:                     v = 5'd29;
         4'd4, 4'd6, 4'd9, 4'd11:  v = 5'd30;
         default:                  v = 5'd31;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/dtas_divider.sv =====
// ----------------------------------------------------------------------------
// dtas_divider
// Division by a constant: reciprocal estimate, residue, one correction.
// ----------------------------------------------------------------------------
module dtas_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [25:0] dividend,
   input  logic [17:0] divisor,
   input  logic [23:0] recip,
   output logic [25:0] quotient,
   output logic [17:0] remainder,
   output logic        done
);
   import dtas_pkg::*;

   div_phase_type phase_ff, phase_in;
   logic [25:0]   x_ff, x_in;
   logic [17:0]   k_ff, k_in;
   logic [23:0]   rcp_ff, rcp_in;
   logic [25:0]   quot_ff, quot_in;
   logic [18:0]   res_ff, res_in;
   logic          done_ff, done_in;
   logic [49:0]   prod_est;
   logic [43:0]   prod_back;
   logic [25:0]   diff;

   // estimate is the true quotient or one below it
   assign prod_est  = {24'b0, x_ff} * {26'b0, rcp_ff};
   assign prod_back = {18'b0, quot_ff} * {26'b0, k_ff};
   assign diff      = x_ff - prod_back[25:0];

   always_comb begin
      phase_in = phase_ff;
      x_in     = x_ff;
      k_in     = k_ff;
      rcp_in   = rcp_ff;
      quot_in  = quot_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      if (load) begin
         x_in     = dividend;
         k_in     = divisor;
         rcp_in   = recip;
         phase_in = DP_EST;
      end else begin
         case (phase_ff)
            DP_IDLE: ;
            DP_EST: begin
               quot_in  = {2'b0, prod_est[49:26]};
               phase_in = DP_RES;
            end
            DP_RES: begin
               res_in   = diff[18:0];
               phase_in = DP_FIX;
            end
            DP_FIX: begin
               if (res_ff >= {1'b0, k_ff}) begin
                  quot_in = quot_ff + 26'd1;
                  res_in  = res_ff - {1'b0, k_ff};
               end
               done_in  = 1'b1;
               phase_in = DP_IDLE;
            end
            default: phase_in = DP_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= DP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      x_ff    <= x_in;
      k_ff    <= k_in;
      rcp_ff  <= rcp_in;
      quot_ff <= quot_in;
      res_ff  <= res_in;
   end

   assign quotient  = quot_ff;
   assign remainder = res_ff[17:0];
   assign done      = done_ff;
endmodule

// ===== rtl/core/dtas_datapath.sv =====
// ----------------------------------------------------------------------------
// dtas_datapath
// Field registers, divider operand selection and result packing.
// ----------------------------------------------------------------------------
module dtas_datapath (
   input  logic             clock,
   input  logic             reset,
   input  dtas_pkg::req_type req_data,
   input  dtas_pkg::cmd_type cmd,
   output dtas_pkg::stat_type stat,
   output logic             rsp_strobe,
   output dtas_pkg::rsp_type rsp_data
);
   import dtas_pkg::*;

   req_type            req_ff;
   logic [24:0]        t_ff;
   logic [6:0]         d_ff, m_ff, mi_ff, s_ff, ry_ff;
   logic [11:0]        y_ff;
   logic [4:0]         h_ff;
   logic [5:0]         cy_ff, ca_ff;
   logic signed [16:0] days_ff;
   logic [16:0]        rem_ff;
   logic [2:0]         era_ff;
   logic [17:0]        doe_ff;
   logic [6:0]         a_ff;
   logic [2:0]         b_ff;
   logic [8:0]         yoe_ff;
   logic [1:0]         yc_ff;
   logic [3:0]         mp_ff;
   logic [4:0]         dd_ff;
   logic [4:0]         nh_ff;
   logic [5:0]         nmi_ff, ns_ff;
   logic               strobe_ff;
   rsp_type            rsp_ff, rsp_in;

   logic [25:0] dividend, quo;
   logic [17:0] rmd;
   logic        div_done;
   logic        leap, date_ok, time_ok;
   logic [11:0] ya;
   logic [21:0] dn;
   logic signed [22:0] g;
   logic [16:0] tsec;
   logic signed [33:0] usum;
   logic [17:0] yoe_num, doy_w;
   logic [8:0]  doy;
   logic [3:0]  m2;
   logic [11:0] year;

   dtas_divider u_div (
      .clock(clock), .reset(reset), .load(cmd.issue), .dividend(dividend),
      .divisor(step_divisor(cmd.step)), .recip(step_recip(cmd.step)),
      .quotient(quo), .remainder(rmd), .done(div_done)
   );

   assign leap    = (y_ff[1:0] == 2'd0) && ((ry_ff != '0) || (cy_ff[1:0] == 2'd0));
   assign date_ok = (y_ff >= 12'd1900) && (y_ff <= 12'd2999) && (m_ff >= 7'd1)
                    && (m_ff <= 7'd12) && (d_ff >= 7'd1)
                    && (d_ff <= {2'b0, month_len(m_ff[3:0])})
                    && !((m_ff == 7'd2) && (d_ff == 7'd29) && !leap);
   assign time_ok = (h_ff <= 5'd23) && (mi_ff <= 7'd59) && (s_ff <= 7'd59);
   assign stat    = '{div_done: div_done, input_ok: date_ok && time_ok};

   assign ya   = y_ff - ((m_ff <= 7'd2) ? 12'd1 : 12'd0);
   assign dn   = 22'(ya) * 22'd365 + 22'(ya[11:2]) - 22'(ca_ff) + 22'(ca_ff[5:2])
               + 22'(month_offset(m_ff[3:0])) + 22'(d_ff) - 22'd1;
   assign g    = $signed({1'b0, dn}) + {{6{days_ff[16]}}, days_ff};
   assign tsec = 17'(h_ff) * 17'd3600 + 17'(mi_ff) * 17'd60 + 17'(s_ff);
   // bias by whole days so the floored split becomes an unsigned divide
   assign usum = $signed({17'b0, tsec})
               + $signed({{2{req_ff.seconds_to_add[31]}}, req_ff.seconds_to_add})
               + 34'sd2147558400;
   assign yoe_num = doe_ff - 18'(a_ff) + 18'(b_ff)
                  - ((doe_ff == 18'd146096) ? 18'd1 : 18'd0);
   assign doy_w = doe_ff - (18'(yoe_ff) * 18'd365 + 18'(yoe_ff[8:2]) - 18'(yc_ff));
   assign doy   = doy_w[8:0];
   assign m2    = (mp_ff < 4'd10) ? mp_ff + 4'd3 : mp_ff - 4'd9;
   assign year  = 12'(era_ff) * 12'd400 + 12'(yoe_ff) + ((m2 <= 4'd2) ? 12'd1 : 12'd0);

   always_comb begin
      case (cmd.step)
         S_DATE0:  dividend = {1'b0, req_ff.date_code};
         S_TIME0:  dividend = {8'b0, req_ff.time_code};
         S_DATE1:  dividend = {1'b0, t_ff};
         S_TIME1:  dividend = {1'b0, t_ff};
         S_LEAP:   dividend = {14'b0, y_ff};
         S_YADJ:   dividend = {14'b0, ya};
         // split off the low seven bits of 86400 = 675 * 128
         S_SECS:   dividend = usum[32:7];
         S_ERA:    dividend = {3'b0, g};
         S_D1460:  dividend = {8'b0, doe_ff};
         S_D36524: dividend = {8'b0, doe_ff};
         S_YOE:    dividend = {8'b0, yoe_num};
         S_Y100:   dividend = {17'b0, yoe_ff};
         S_MP:     dividend = 26'(doy) * 26'd5 + 26'd2;
         S_DAY:    dividend = 26'(mp_ff) * 26'd153 + 26'd2;
         S_HOUR:   dividend = {9'b0, rem_ff};
         S_MIN:    dividend = {1'b0, t_ff};
         default:  dividend = '0;
      endcase
   end

   always_comb begin
      rsp_in = '0;
      if (!stat.input_ok) begin
         rsp_in.status = STATUS_INVALID;
      end else if ((year < 12'd1900) || (year > 12'd2999)) begin
         rsp_in.status = STATUS_RANGE;
      end else begin
         rsp_in.new_date_code = 25'(year) * 25'd10000 + 25'(m2) * 25'd100 + 25'(dd_ff);
         rsp_in.new_time_code = 18'(nh_ff) * 18'd10000 + 18'(nmi_ff) * 18'd100
                              + 18'(ns_ff);
         rsp_in.status        = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.finish;
      end
      if (cmd.load) req_ff <= req_data;
      if (cmd.finish) rsp_ff <= rsp_in;
      if (cmd.latch) begin
         case (cmd.step)
            S_DATE0:  begin d_ff <= rmd[6:0];  t_ff <= quo[24:0]; end
            S_DATE1:  begin m_ff <= rmd[6:0];  y_ff <= quo[11:0]; end
            S_TIME0:  begin s_ff <= rmd[6:0];  t_ff <= quo[24:0]; end
            S_TIME1:  begin mi_ff <= rmd[6:0]; h_ff <= quo[4:0];  end
            S_LEAP:   begin ry_ff <= rmd[6:0]; cy_ff <= quo[5:0]; end
            S_YADJ:   ca_ff <= quo[5:0];
            S_SECS:   begin
               rem_ff  <= {rmd[9:0], usum[6:0]};
               days_ff <= $signed({1'b0, quo[15:0]}) - 17'sd24856;
            end
            S_ERA:    begin era_ff <= quo[2:0]; doe_ff <= rmd; end
            S_D1460:  a_ff <= quo[6:0];
            S_D36524: b_ff <= quo[2:0];
            S_YOE:    yoe_ff <= quo[8:0];
            S_Y100:   yc_ff <= quo[1:0];
            S_MP:     mp_ff <= quo[3:0];
            S_DAY:    dd_ff <= 5'(doy - quo[8:0] + 9'd1);
            S_HOUR:   begin nh_ff <= quo[4:0]; t_ff <= {13'b0, rmd[11:0]}; end
            S_MIN:    begin nmi_ff <= quo[5:0]; ns_ff <= rmd[5:0]; end
            default:  ;
         endcase
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;
endmodule

// ===== rtl/core/dtas_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtas_ctrl
// Sequencer that walks the datapath through its division steps.
// ----------------------------------------------------------------------------
module dtas_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  dtas_pkg::stat_type stat,
   output dtas_pkg::cmd_type  cmd,
   output logic               busy
);
   import dtas_pkg::*;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= S_DATE0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      cmd.step   = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               step_in  = S_DATE0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (stat.div_done) begin
               cmd.latch = 1'b1;
               // drop the rest of the work once the input proves bad
               if (((step_ff == S_YADJ) && !stat.input_ok) || (step_ff == S_MIN)) begin
                  state_in = ST_FIN;
               end else begin
                  step_in  = step_type'(step_ff + 5'd1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = state_ff != ST_IDLE;
endmodule

// ===== rtl/core/date_time_add_seconds.sv =====
// ----------------------------------------------------------------------------
// date_time_add_seconds
// Adds a signed number of seconds to a YYYYMMDD date and HHMMSS time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The result appears
// on rsp_data for exactly one cycle with rsp_strobe high; the receiver cannot
// stall it, so capture it then. A valid request runs sixteen divisions by
// constants on one shared reciprocal-multiply divider, each in the steps
// operand load, estimate, residue, correction and result capture, and then
// the result is packed and registered. A request with a bad date or time
// finishes after six divisions. busy falls as the strobe rises, so the next
// request may be given in the strobe cycle.
module date_time_add_seconds (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dtas_pkg::req_type req_data,
   output logic             rsp_strobe,
   output dtas_pkg::rsp_type rsp_data
);
   import dtas_pkg::*;
`include "assert_macros.svh"

   cmd_type  cmd;
   stat_type stat;
   logic     rsp_fail, rsp_zero;

   dtas_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
   );

   dtas_datapath u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .cmd(cmd), .stat(stat),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   assign rsp_fail = rsp_strobe && (rsp_data.status != STATUS_OK);
   assign rsp_zero = (rsp_data.new_date_code == '0) && (rsp_data.new_time_code == '0);

   `ASSERT_IMPLY(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_fail, rsp_zero)
   `ASSERT_IMPLY(a_status_code, clock, reset, rsp_strobe, rsp_data.status <= STATUS_RANGE)
endmodule

// ===== sim/tb_date_time_add_seconds.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_date_time_add_seconds
// Drives date/time/offset requests into the adder and compares every strobed
// result with a calendar predictor, oldest outstanding request first.
// ----------------------------------------------------------------------------
module tb_date_time_add_seconds;
   import dtas_pkg::*;

   class calendar_scoreboard;
      rsp_type pending_sums[$];
      int      errors;

      function new();
         errors = 0;
      endfunction

      static function bit leap_year(longint y);
         return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      endfunction

      static function bit date_valid(longint code);
         longint y, m, d, mlen;
         y = code / 10000;
         m = (code / 100) % 100;
         d = code % 100;
         if (y < 1900 || y > 2999 || m < 1 || m > 12) return 0;
         case (m)
            2:          mlen = 29;
            4, 6, 9, 11: mlen = 30;
            default:    mlen = 31;
         endcase
         if (d < 1 || d > mlen) return 0;
         if (m == 2 && d == 29 && !leap_year(y)) return 0;
         return 1;
      endfunction

      static function longint days_from_march(longint code);
         longint y, m, d, moff;
         y = code / 10000;
         m = (code / 100) % 100;
         d = code % 100;
         if (m <= 2) y = y - 1;
         case (m)
            1: moff = 306;  2: moff = 337;  4: moff = 31;   5: moff = 61;
            6: moff = 92;   7: moff = 122;  8: moff = 153;  9: moff = 184;
            10: moff = 214; 11: moff = 245; 12: moff = 275;
            default: moff = 0;
         endcase
         return 365 * y + y / 4 - y / 100 + y / 400 + moff + d - 1;
      endfunction

      static function rsp_type sum_of(req_type r);
         rsp_type o;
         longint dc, tc, secs, days, g, era, doe, yoe, doy, mp, d, m, y;
         dc = r.date_code;
         tc = r.time_code;
         o = '0;
         if (!date_valid(dc) || tc / 10000 > 23 || (tc / 100) % 100 > 59 || tc % 100 > 59)
         begin
            o.status = STATUS_INVALID;
            return o;
         end
         secs = (tc / 10000) * 3600 + ((tc / 100) % 100) * 60 + tc % 100
              + longint'(r.seconds_to_add);
         days = secs / 86400;
         secs = secs % 86400;
         if (secs < 0) begin
            secs = secs + 86400;
            days = days - 1;
         end
         g = days_from_march(dc) + days;
         era = g / 146097;
         doe = g % 146097;
         yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
         doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
         mp = (5 * doy + 2) / 153;
         d = doy - (153 * mp + 2) / 5 + 1;
         m = (mp < 10) ? mp + 3 : mp - 9;
         y = era * 400 + yoe + ((m <= 2) ? 1 : 0);
         if (y < 1900 || y > 2999) begin
            o.status = STATUS_RANGE;
            return o;
         end
         o.new_date_code = 25'(y * 10000 + m * 100 + d);
         o.new_time_code = 18'((secs / 3600) * 10000 + ((secs / 60) % 60) * 100 + secs % 60);
         o.status = STATUS_OK;
         return o;
      endfunction

      function void note_request(req_type r);
         pending_sums.push_back(sum_of(r));
      endfunction

      function void check_sum(rsp_type got);
         rsp_type want;
         if (pending_sums.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending_sums.pop_front();
         if (got.new_date_code !== want.new_date_code)
            $display("%0t: date expected %0d actual %0d", $time, want.new_date_code,
                     got.new_date_code);
         if (got.new_time_code !== want.new_time_code)
            $display("%0t: time expected %0d actual %0d", $time, want.new_time_code,
                     got.new_time_code);
         if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         if (got !== want) errors++;
      endfunction
   endclass

   logic    clock, reset, start, busy, rsp_strobe;
   req_type req_data;
   rsp_type rsp_data;
   int      idle_pct;
   calendar_scoreboard sb;

   date_time_add_seconds dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("date_time_add_seconds test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) sb.note_request(req_data);
      if (!reset && rsp_strobe) sb.check_sum(rsp_data);
   end

   // hold start until accepted; idle at random beforehand
   task automatic send_request(req_type r);
      do @(posedge clock); while ($urandom_range(99) < idle_pct);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
   endtask

   function automatic logic [24:0] random_date();
      int y, m, d;
      y = (($urandom_range(9) == 0) ? $urandom_range(1899, 1800) : $urandom_range(2999, 1900));
      if ($urandom_range(3) == 0) y = ($urandom_range(1) != 0) ? 1900 : 2999;
      m = $urandom_range(12, 1);
      d = $urandom_range(28, 1);
      if ($urandom_range(7) == 0) d = $urandom_range(31, 29);
      if ($urandom_range(15) == 0) return 25'($urandom);
      return 25'(y * 10000 + m * 100 + d);
   endfunction

   function automatic req_type random_request();
      req_type r;
      int sel;
      r.date_code = random_date();
      r.time_code = 18'($urandom_range(23) * 10000 + $urandom_range(59) * 100
                        + $urandom_range(59));
      if ($urandom_range(15) == 0) r.time_code = 18'($urandom);
      sel = $urandom_range(3);
      case (sel)
         0: r.seconds_to_add = $urandom;
         1: r.seconds_to_add = int'($urandom_range(200000)) - 100000;
         2: r.seconds_to_add = int'($urandom_range(20000000)) - 10000000;
         default: r.seconds_to_add = ($urandom_range(1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      endcase
      return r;
   endfunction

   req_type dir[$];
   int      wait_cycles;

   initial begin
      sb = new();
      reset = 1;
      start = 0;
      req_data = '0;
      idle_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // extremes, leap rules, invalid fields, overflow and underflow
      dir.push_back('{25'd19000101, 18'd0, 32'sd0});
      dir.push_back('{25'd29991231, 18'd235959, 32'sd1});
      dir.push_back('{25'd19000101, 18'd0, -32'sd1});
      dir.push_back('{25'd29991231, 18'd235959, 32'sh7fffffff});
      dir.push_back('{25'd19000101, 18'd0, 32'sh80000000});
      dir.push_back('{25'd20000228, 18'd235959, 32'sd1});
      dir.push_back('{25'd21000228, 18'd235959, 32'sd1});
      dir.push_back('{25'd20240229, 18'd120000, 32'sd86400});
      dir.push_back('{25'd19000229, 18'd0, 32'sd0});
      dir.push_back('{25'd20000229, 18'd0, -32'sd86400});
      dir.push_back('{25'd20231301, 18'd0, 32'sd0});
      dir.push_back('{25'd20230100, 18'd0, 32'sd0});
      dir.push_back('{25'd20230431, 18'd0, 32'sd0});
      dir.push_back('{25'd18991231, 18'd0, 32'sd0});
      dir.push_back('{25'd30000101, 18'd0, 32'sd0});
      dir.push_back('{25'd20230101, 18'd240000, 32'sd0});
      dir.push_back('{25'd20230101, 18'd6000, 32'sd0});
      dir.push_back('{25'd20230101, 18'd60, 32'sd0});
      dir.push_back('{25'h1ffffff, 18'h3ffff, 32'sh7fffffff});
      dir.push_back('{25'd20230301, 18'd0, -32'sd1});
      dir.push_back('{25'd20381231, 18'd100000, 32'sh55555555});
      foreach (dir[i]) send_request(dir[i]);
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 15 : (phase == 1) ? 60 : 0;
         repeat (170) send_request(random_request());
      end
      wait_cycles = 0;
      while (sb.pending_sums.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (700) @(posedge clock);
      if (sb.errors == 0 && sb.pending_sums.size() == 0)
         $display("date_time_add_seconds test passed");
      else
         $display("date_time_add_seconds test failed");
      $finish;
   end
endmodule
